// File: src/sql_statement_splitter_top_macros.svh
// Assertion macros for the SQL statement splitter.
`ifndef SQL_STATEMENT_SPLITTER_TOP_MACROS_SVH
`define SQL_STATEMENT_SPLITTER_TOP_MACROS_SVH

// Clocked on aclk, disabled while aresetn is low.
`define SQLSS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Same check, only while a result is presented.
`define SQLSS_ASSERT_OUT(label, prop, msg) \
    `SQLSS_ASSERT(label, (m_valid |-> (prop)), msg)

`endif

// File: src/sqlss_pkg.sv
// Package: types and byte codes for the SQL statement splitter.
`timescale 1ns / 1ps

package sqlss_pkg;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_SQ    = 8'h27;
    localparam logic [7:0] CH_DQ    = 8'h22;

    typedef enum logic [1:0] {
        QUOTE_NONE   = 2'd0,
        QUOTE_SINGLE = 2'd1,
        QUOTE_DOUBLE = 2'd2
    } quote_kind_t;

    typedef struct packed {
        quote_kind_t quote_kind;
        logic        escape_pending;
        logic        line_comment;
        logic        block_comment;
        logic        dash_pending;
        logic        slash_pending;
        logic        star_pending;
        logic        has_text;
    } scan_state_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       in_statement;
        logic       statement_end;
        logic       statement_blank;
        logic       script_end;
        logic       dropped_open;
    } scan_result_t;

endpackage

// File: src/sql_statement_splitter_top.sv
// Top level of the SQL statement splitter: input register, scan logic, result register.
`timescale 1ns / 1ps

// Splits an SQL script into statements, one byte per transfer, byte 0 ending the
// script. Every byte comes back as one result: passed through, marked as statement
// text or not, with flags for a closing ';' or end of script, a blank statement,
// and a statement dropped because the script ended inside a quote or comment.
// Throughput is one byte per cycle, back to back, while m_ready holds high. A byte
// passes through the input register and then the result register before its result
// is valid. The rate is set by the scan state update, which completes as a byte
// moves from the input register to the result register. A stalled result register
// holds the input register and then the input; nothing is lost or reordered.

`include "sql_statement_splitter_top_macros.svh"

module sql_statement_splitter_top (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_text_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_in_statement,
    output logic       m_statement_end,
    output logic       m_statement_blank,
    output logic       m_script_end,
    output logic       m_dropped_open
);

    logic                    in_valid_reg;
    logic [7:0]              in_byte_reg;
    logic                    out_valid_reg;
    sqlss_pkg::scan_result_t out_reg;
    sqlss_pkg::scan_state_t  state_reg;
    sqlss_pkg::scan_state_t  state_next;
    sqlss_pkg::scan_result_t result_next;
    logic                    advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    sqlss_scan u_scan (
        .i_state  (state_reg),
        .i_byte   (in_byte_reg),
        .o_state  (state_next),
        .o_result (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg <= s_text_byte;
        end
        if (advance) begin
            out_reg <= result_next;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_out_byte        = out_reg.out_byte;
    assign m_in_statement    = out_reg.in_statement;
    assign m_statement_end   = out_reg.statement_end;
    assign m_statement_blank = out_reg.statement_blank;
    assign m_script_end      = out_reg.script_end;
    assign m_dropped_open    = out_reg.dropped_open;

    `SQLSS_ASSERT(a_clear_on_nul,
        (advance && in_byte_reg == sqlss_pkg::CH_NUL |=> state_reg == '0),
        "state not cleared after end of script")
    `SQLSS_ASSERT_OUT(a_blank_needs_end, (!m_statement_blank || m_statement_end),
        "blank flag without statement end")
    `SQLSS_ASSERT_OUT(a_drop_needs_script_end, (!m_dropped_open || m_script_end),
        "drop flag without end of script")
    `SQLSS_ASSERT_OUT(a_end_not_text, (!m_statement_end || !m_in_statement),
        "closing byte marked as statement text")
    `SQLSS_ASSERT(a_stall_holds_input,
        (in_valid_reg && !advance |=> in_valid_reg && $stable(in_byte_reg)),
        "input register lost a stalled byte")

endmodule

// File: src/sqlss_scan.sv
// Next-state and result logic of the splitter for one script byte.
`timescale 1ns / 1ps

module sqlss_scan (
    input  sqlss_pkg::scan_state_t  i_state,
    input  logic [7:0]              i_byte,
    output sqlss_pkg::scan_state_t  o_state,
    output sqlss_pkg::scan_result_t o_result
);

    sqlss_pkg::scan_state_t nxt;
    sqlss_pkg::quote_kind_t kind;
    logic ins;
    logic send;
    logic blank;
    logic drop;
    logic handled;
    logic is_nul;

    always_comb begin
        nxt     = i_state;
        ins     = 1'b1;
        send    = 1'b0;
        blank   = 1'b0;
        drop    = 1'b0;
        handled = 1'b0;
        is_nul  = (i_byte == sqlss_pkg::CH_NUL);
        kind    = (i_byte == sqlss_pkg::CH_SQ) ? sqlss_pkg::QUOTE_SINGLE
                                               : sqlss_pkg::QUOTE_DOUBLE;

        if (i_state.escape_pending) begin
            nxt.escape_pending = 1'b0;
            drop = is_nul;
        end else if (i_state.line_comment) begin
            if (i_byte == sqlss_pkg::CH_LF) begin
                nxt.line_comment = 1'b0;
            end else if (is_nul) begin
                drop = 1'b1;
            end
        end else if (i_state.block_comment) begin
            if (is_nul) begin
                drop = 1'b1;
            end else if (i_state.star_pending && i_byte == sqlss_pkg::CH_SLASH) begin
                nxt.block_comment = 1'b0;
                nxt.star_pending  = 1'b0;
            end else begin
                nxt.star_pending = (i_byte == sqlss_pkg::CH_STAR);
            end
        end else begin
            if (i_state.dash_pending) begin
                nxt.dash_pending = 1'b0;
                if (i_byte == sqlss_pkg::CH_DASH) begin
                    nxt.line_comment = 1'b1;
                    handled = 1'b1;
                end
            end
            if (i_state.slash_pending) begin
                nxt.slash_pending = 1'b0;
                if (i_byte == sqlss_pkg::CH_STAR) begin
                    nxt.block_comment = 1'b1;
                    nxt.star_pending  = 1'b1;
                    handled = 1'b1;
                end
            end
            if (!handled) begin
                if (i_byte == sqlss_pkg::CH_SQ || i_byte == sqlss_pkg::CH_DQ) begin
                    if (i_state.quote_kind == sqlss_pkg::QUOTE_NONE) begin
                        nxt.quote_kind = kind;
                    end else if (i_state.quote_kind == kind) begin
                        nxt.quote_kind = sqlss_pkg::QUOTE_NONE;
                    end
                end else if (i_byte == sqlss_pkg::CH_BSL) begin
                    if (i_state.quote_kind != sqlss_pkg::QUOTE_NONE) begin
                        nxt.escape_pending = 1'b1;
                    end
                end else if (i_byte == sqlss_pkg::CH_SEMI || is_nul) begin
                    if (i_state.quote_kind != sqlss_pkg::QUOTE_NONE) begin
                        drop = is_nul;
                    end else begin
                        send  = 1'b1;
                        blank = !i_state.has_text;
                        ins   = 1'b0;
                    end
                end else if (i_state.quote_kind == sqlss_pkg::QUOTE_NONE) begin
                    case (i_byte)
                        sqlss_pkg::CH_DASH:  nxt.dash_pending  = 1'b1;
                        sqlss_pkg::CH_HASH:  nxt.line_comment  = 1'b1;
                        sqlss_pkg::CH_SLASH: nxt.slash_pending = 1'b1;
                        default: ;
                    endcase
                end
            end
        end

        if (is_nul) begin
            ins = 1'b0;
        end

        if (send) begin
            nxt.has_text = 1'b0;
        end else if (ins && !(i_byte inside {sqlss_pkg::CH_SPACE, sqlss_pkg::CH_CR,
                                             sqlss_pkg::CH_LF, sqlss_pkg::CH_TAB})) begin
            nxt.has_text = 1'b1;
        end

        if (is_nul) begin
            nxt = '0;
        end
    end

    assign o_state                  = nxt;
    assign o_result.out_byte        = i_byte;
    assign o_result.in_statement    = ins;
    assign o_result.statement_end   = send;
    assign o_result.statement_blank = send & blank;
    assign o_result.script_end      = is_nul;
    assign o_result.dropped_open    = drop;

endmodule

// File: dv/sql_statement_splitter_checker.sv
// Checker for the SQL statement splitter: scan predictor, expected results, compare.
`timescale 1ns / 1ps

module sql_statement_splitter_checker (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic [7:0] s_text_byte,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic [7:0] m_out_byte,
    input  logic       m_in_statement,
    input  logic       m_statement_end,
    input  logic       m_statement_blank,
    input  logic       m_script_end,
    input  logic       m_dropped_open,
    output int         fail_count,
    output int         pending_count
);

    sqlss_pkg::scan_state_t  scan_st;
    sqlss_pkg::scan_result_t expected_results[$];

    function automatic sqlss_pkg::scan_result_t scan_byte(input logic [7:0] b);
        sqlss_pkg::scan_result_t r;
        logic                    ins;
        logic                    send;
        logic                    drop;
        logic                    handled;
        sqlss_pkg::quote_kind_t  k;
        ins     = 1'b1;
        send    = 1'b0;
        drop    = 1'b0;
        handled = 1'b0;
        if (scan_st.escape_pending) begin
            scan_st.escape_pending = 1'b0;
            drop = (b == sqlss_pkg::CH_NUL);
        end else if (scan_st.line_comment) begin
            if (b == sqlss_pkg::CH_LF) scan_st.line_comment = 1'b0;
            else if (b == sqlss_pkg::CH_NUL) drop = 1'b1;
        end else if (scan_st.block_comment) begin
            if (b == sqlss_pkg::CH_NUL) begin
                drop = 1'b1;
            end else if (scan_st.star_pending && b == sqlss_pkg::CH_SLASH) begin
                scan_st.block_comment = 1'b0;
                scan_st.star_pending  = 1'b0;
            end else begin
                scan_st.star_pending = (b == sqlss_pkg::CH_STAR);
            end
        end else begin
            if (scan_st.dash_pending) begin
                scan_st.dash_pending = 1'b0;
                if (b == sqlss_pkg::CH_DASH) begin
                    scan_st.line_comment = 1'b1;
                    handled = 1'b1;
                end
            end
            if (scan_st.slash_pending) begin
                scan_st.slash_pending = 1'b0;
                if (b == sqlss_pkg::CH_STAR) begin
                    // the opening star also counts toward the closing pair
                    scan_st.block_comment = 1'b1;
                    scan_st.star_pending  = 1'b1;
                    handled = 1'b1;
                end
            end
            if (!handled) begin
                if (b == sqlss_pkg::CH_SQ || b == sqlss_pkg::CH_DQ) begin
                    k = (b == sqlss_pkg::CH_SQ) ? sqlss_pkg::QUOTE_SINGLE
                                                : sqlss_pkg::QUOTE_DOUBLE;
                    if (scan_st.quote_kind == sqlss_pkg::QUOTE_NONE) begin
                        scan_st.quote_kind = k;
                    end else if (scan_st.quote_kind == k) begin
                        scan_st.quote_kind = sqlss_pkg::QUOTE_NONE;
                    end
                end else if (b == sqlss_pkg::CH_BSL) begin
                    if (scan_st.quote_kind != sqlss_pkg::QUOTE_NONE) begin
                        scan_st.escape_pending = 1'b1;
                    end
                end else if (b == sqlss_pkg::CH_SEMI || b == sqlss_pkg::CH_NUL) begin
                    if (scan_st.quote_kind != sqlss_pkg::QUOTE_NONE) begin
                        drop = (b == sqlss_pkg::CH_NUL);
                    end else begin
                        send = 1'b1;
                        ins  = 1'b0;
                    end
                end else if (scan_st.quote_kind == sqlss_pkg::QUOTE_NONE) begin
                    if (b == sqlss_pkg::CH_DASH) scan_st.dash_pending = 1'b1;
                    else if (b == sqlss_pkg::CH_HASH) scan_st.line_comment = 1'b1;
                    else if (b == sqlss_pkg::CH_SLASH) scan_st.slash_pending = 1'b1;
                end
            end
        end
        if (b == sqlss_pkg::CH_NUL) ins = 1'b0;
        r.out_byte        = b;
        r.in_statement    = ins;
        r.statement_end   = send;
        r.statement_blank = send && !scan_st.has_text;
        r.script_end      = (b == sqlss_pkg::CH_NUL);
        r.dropped_open    = drop;
        if (send) begin
            scan_st.has_text = 1'b0;
        end else if (ins && !(b == sqlss_pkg::CH_SPACE || b == sqlss_pkg::CH_CR ||
                              b == sqlss_pkg::CH_LF || b == sqlss_pkg::CH_TAB)) begin
            scan_st.has_text = 1'b1;
        end
        if (b == sqlss_pkg::CH_NUL) scan_st = '0;
        return r;
    endfunction

    always @(posedge aclk) begin
        sqlss_pkg::scan_result_t want;
        sqlss_pkg::scan_result_t got;
        sqlss_pkg::scan_result_t predicted;
        if (!aresetn) begin
            scan_st = '0;
            expected_results.delete();
            pending_count = 0;
            fail_count    = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual byte %h",
                             $time, m_out_byte);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    got.out_byte        = m_out_byte;
                    got.in_statement    = m_in_statement;
                    got.statement_end   = m_statement_end;
                    got.statement_blank = m_statement_blank;
                    got.script_end      = m_script_end;
                    got.dropped_open    = m_dropped_open;
                    if (got !== want) begin
                        $display("%0t: result mismatch, expected %h, actual %h",
                                 $time, want, got);
                        fail_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                predicted = scan_byte(s_text_byte);
                expected_results.insert(expected_results.size(), predicted);
            end
            pending_count = expected_results.size();
        end
    end

endmodule

// File: dv/sql_statement_splitter_top_tb.sv
// Testbench top for the SQL statement splitter: clock, reset, byte stimulus, verdict.
`timescale 1ns / 1ps

module sql_statement_splitter_top_tb;

    localparam int CYCLE_LIMIT = 400000;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_text_byte = 8'h00;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_out_byte;
    logic       m_in_statement;
    logic       m_statement_end;
    logic       m_statement_blank;
    logic       m_script_end;
    logic       m_dropped_open;
    int         fail_count;
    int         pending_count;
    int         send_idle = 29;
    int         recv_idle = 77;
    int         bytes_sent = 0;
    int         cycle_count = 0;

    sql_statement_splitter_top dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_text_byte       (s_text_byte),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_out_byte        (m_out_byte),
        .m_in_statement    (m_in_statement),
        .m_statement_end   (m_statement_end),
        .m_statement_blank (m_statement_blank),
        .m_script_end      (m_script_end),
        .m_dropped_open    (m_dropped_open)
    );

    sql_statement_splitter_checker checker_i (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_text_byte       (s_text_byte),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_out_byte        (m_out_byte),
        .m_in_statement    (m_in_statement),
        .m_statement_end   (m_statement_end),
        .m_statement_blank (m_statement_blank),
        .m_script_end      (m_script_end),
        .m_dropped_open    (m_dropped_open),
        .fail_count        (fail_count),
        .pending_count     (pending_count)
    );

    always #5 aclk = ~aclk;

    always @(negedge aclk) m_ready <= ($urandom_range(99) >= recv_idle);

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // called at a falling edge; returns at the falling edge after the transfer
    task automatic put_byte(input logic [7:0] b);
        if ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            do @(negedge aclk); while ($urandom_range(99) < send_idle);
        end
        s_valid     <= 1'b1;
        s_text_byte <= b;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        bytes_sent++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        wait (pending_count == 0);
        @(negedge aclk);
    endtask

    function automatic logic [7:0] text_byte();
        if ($urandom_range(7) == 0) return 8'($urandom_range(1, 255));
        return 8'($urandom_range(8'h20, 8'h7E));
    endfunction

    function automatic logic [7:0] word_byte();
        if ($urandom_range(3) == 0) return 8'($urandom_range(8'h30, 8'h39));
        return 8'($urandom_range(8'h61, 8'h7A));
    endfunction

    task automatic put_word();
        repeat ($urandom_range(1, 6)) put_byte(word_byte());
    endtask

    task automatic put_quoted();
        logic [7:0] q;
        q = $urandom_range(1) ? sqlss_pkg::CH_SQ : sqlss_pkg::CH_DQ;
        put_byte(q);
        repeat ($urandom_range(0, 5)) begin
            if ($urandom_range(4) == 0) begin
                put_byte(sqlss_pkg::CH_BSL);
                put_byte(text_byte());
            end else begin
                put_byte(text_byte());
            end
        end
        put_byte(q);
    endtask

    task automatic put_line_comment();
        logic [7:0] c;
        if ($urandom_range(1)) begin
            put_byte(sqlss_pkg::CH_DASH);
            put_byte(sqlss_pkg::CH_DASH);
        end else begin
            put_byte(sqlss_pkg::CH_HASH);
        end
        repeat ($urandom_range(0, 6)) begin
            c = text_byte();
            put_byte(c == sqlss_pkg::CH_LF ? sqlss_pkg::CH_SPACE : c);
        end
        put_byte(sqlss_pkg::CH_LF);
    endtask

    task automatic put_block_comment();
        put_byte(sqlss_pkg::CH_SLASH);
        put_byte(sqlss_pkg::CH_STAR);
        repeat ($urandom_range(0, 6)) begin
            put_byte($urandom_range(3) == 0 ? sqlss_pkg::CH_STAR : text_byte());
        end
        put_byte(sqlss_pkg::CH_STAR);
        put_byte(sqlss_pkg::CH_SLASH);
    endtask

    // script cut off inside a quote, escape or comment
    task automatic put_open_end();
        case ($urandom_range(4))
            0: put_byte(sqlss_pkg::CH_SQ);
            1: begin
                put_byte(sqlss_pkg::CH_DQ);
                put_byte(sqlss_pkg::CH_BSL);
            end
            2: put_byte(sqlss_pkg::CH_HASH);
            3: begin
                put_byte(sqlss_pkg::CH_DASH);
                put_byte(sqlss_pkg::CH_DASH);
            end
            default: begin
                put_byte(sqlss_pkg::CH_SLASH);
                put_byte(sqlss_pkg::CH_STAR);
            end
        endcase
        if ($urandom_range(1)) put_word();
        put_byte(sqlss_pkg::CH_NUL);
    endtask

    task automatic put_token();
        logic [7:0] ws[4];
        ws = '{sqlss_pkg::CH_SPACE, sqlss_pkg::CH_TAB, sqlss_pkg::CH_CR, sqlss_pkg::CH_LF};
        case ($urandom_range(19))
            0, 1, 2, 3, 4, 5: put_word();
            6, 7: repeat ($urandom_range(1, 3)) put_byte(ws[2'($urandom_range(3))]);
            8, 9: put_byte(sqlss_pkg::CH_SEMI);
            10, 11: put_quoted();
            12: put_line_comment();
            13: put_block_comment();
            14: begin
                case ($urandom_range(2))
                    0: put_byte(sqlss_pkg::CH_DASH);
                    1: put_byte(sqlss_pkg::CH_SLASH);
                    default: put_byte(sqlss_pkg::CH_STAR);
                endcase
                put_byte(word_byte());
            end
            15, 16: put_byte(8'($urandom_range(0, 255)));
            17: put_byte(sqlss_pkg::CH_NUL);
            18: put_open_end();
            default: if ($urandom_range(9) == 0) drain(); else put_word();
        endcase
    endtask

    task automatic run_phase(input int s_idle, input int r_idle, input int count);
        int target;
        send_idle = s_idle;
        recv_idle = r_idle;
        target = bytes_sent + count;
        while (bytes_sent < target) put_token();
        drain();
    endtask

    initial begin
        logic [7:0] directed[25];
        directed = '{8'hFF, sqlss_pkg::CH_SEMI, sqlss_pkg::CH_SPACE, sqlss_pkg::CH_TAB,
                     sqlss_pkg::CH_SEMI,
                     sqlss_pkg::CH_DASH, sqlss_pkg::CH_DASH, 8'h78, sqlss_pkg::CH_LF,
                     sqlss_pkg::CH_SLASH, sqlss_pkg::CH_STAR, sqlss_pkg::CH_SLASH,
                     sqlss_pkg::CH_DQ, sqlss_pkg::CH_BSL, sqlss_pkg::CH_NUL,
                     sqlss_pkg::CH_HASH, 8'h80, sqlss_pkg::CH_NUL,
                     sqlss_pkg::CH_DASH, 8'h61, sqlss_pkg::CH_SQ, sqlss_pkg::CH_SEMI,
                     sqlss_pkg::CH_SQ, 8'h01, sqlss_pkg::CH_NUL};
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        foreach (directed[i]) put_byte(directed[i]);
        drain();
        run_phase(29, 77, 530);
        run_phase(77, 29, 530);
        run_phase(0, 0, 540);
        repeat (10) @(posedge aclk);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
